// File: src/blm_pkg.sv
package blm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int NUM_LEVELS = 11;
  localparam int LEVEL_BITS = 4;
  localparam int DECIM_BITS = 3;
  localparam int DISCARD_BITS = 4;
  localparam int SKIP_BITS = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 4 * SAMPLE_BITS;
  localparam int THR_BITS = NUM_LEVELS * SAMPLE_BITS;

  localparam logic [DISCARD_BITS-1:0] DISCARD_DETACH = 4'd10;
  localparam logic [DISCARD_BITS-1:0] DISCARD_WAKE = 4'd5;
  localparam logic [DISCARD_BITS-1:0] DISCARD_QUICK = 4'd1;
  localparam logic [SKIP_BITS-1:0] SKIP_ARM = 2'd3;
  localparam logic [LEVEL_BITS-1:0] LEVEL_UNKNOWN = LEVEL_BITS'(NUM_LEVELS);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [THR_BITS-1:0] thr_set_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THR_LOW  = 2'd0,
    CFG_THR_MID  = 2'd1,
    CFG_THR_HIGH = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_POWER_OFF = 2'd1,
    ACT_NEW_LEVEL = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    BAT_EMPTY    = 3'd0,
    BAT_QUARTER  = 3'd1,
    BAT_HALF     = 3'd2,
    BAT_THREE_QT = 3'd3,
    BAT_FULL     = 3'd4,
    BAT_ERROR    = 3'd5
  } bat_state_t;

  typedef struct packed {
    logic       usb_present;
    logic       usb_present_raw;
    logic       stepup_on_battery;
    logic       stepup_powered;
    logic       sample_valid;
    logic [11:0] sample;
    logic       ack;
    logic [3:0] aux_level;
    logic       skip_queue_request;
    logic       error_signal;
  } req_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] pending_level;
    logic [3:0] current_level;
    logic [2:0] battery_state;
    logic       on_usb;
  } rsp_t;

  typedef struct packed {
    logic   found;
    level_t level;
  } quant_t;

  function automatic sample_t thr_at(thr_set_t thr, level_t idx);
    sample_t r;
    r = '0;
    if (idx < LEVEL_UNKNOWN) begin
      r = thr[int'(idx) * SAMPLE_BITS +: SAMPLE_BITS];
    end
    return r;
  endfunction

  function automatic quant_t quantise(thr_set_t thr, sample_t v);
    quant_t q;
    q.found = 1'b0;
    q.level = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (v > thr[i * SAMPLE_BITS +: SAMPLE_BITS]) begin
        q.found = 1'b1;
        q.level = LEVEL_BITS'(i);
      end
    end
    return q;
  endfunction

endpackage

// File: src/blm_core.sv
module blm_core #(
  parameter int LINE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  blm_pkg::req_t     req,
  input  blm_pkg::thr_set_t thr,
  output blm_pkg::rsp_t     rsp
);

  logic usb_mode, usb_mode_next;
  logic last_powered;
  blm_pkg::sample_t line [LINE_DEPTH];
  blm_pkg::sample_t line_next [LINE_DEPTH];
  logic [blm_pkg::DECIM_BITS-1:0] decimate_count, decimate_count_next;
  logic [blm_pkg::DISCARD_BITS-1:0] discard_left, discard_left_next;
  logic [blm_pkg::SKIP_BITS-1:0] skip_left, skip_left_next;
  blm_pkg::level_t level_now, level_now_next;
  blm_pkg::level_t level_pending, level_pending_next;
  blm_pkg::level_t aux_update, aux_update_next;
  logic boot_notify, boot_notify_next;
  logic error_flag, error_flag_next;

  logic vbat_src;
  logic take;
  logic done;
  blm_pkg::sample_t old;
  blm_pkg::quant_t q_old;
  blm_pkg::quant_t q_line;
  blm_pkg::action_t action;
  blm_pkg::bat_state_t bat;

  always_comb begin
    level_now_next = req.ack ? level_pending : level_now;
    boot_notify_next = req.ack ? 1'b0 : boot_notify;
    aux_update_next = req.ack ? '0 : aux_update;
    error_flag_next = error_flag | req.error_signal;
    skip_left_next = req.skip_queue_request ? blm_pkg::SKIP_ARM : skip_left;
    if (req.aux_level != '0) begin
      aux_update_next = req.aux_level;
    end

    usb_mode_next = usb_mode;
    discard_left_next = discard_left;
    level_pending_next = level_pending;
    decimate_count_next = decimate_count;
    for (int k = 0; k < LINE_DEPTH; k++) begin
      line_next[k] = line[k];
    end

    if (!usb_mode && req.usb_present) begin
      for (int k = 0; k < LINE_DEPTH; k++) begin
        line_next[k] = line[0];
      end
      usb_mode_next = 1'b1;
    end else if (usb_mode && !req.usb_present) begin
      usb_mode_next = 1'b0;
      discard_left_next = blm_pkg::DISCARD_DETACH;
    end else if (!last_powered && req.stepup_powered) begin
      discard_left_next = (skip_left_next != '0) ? blm_pkg::DISCARD_QUICK
                                                 : blm_pkg::DISCARD_WAKE;
    end

    vbat_src = req.stepup_on_battery & req.stepup_powered;
    action = blm_pkg::ACT_NONE;
    done = 1'b0;
    take = 1'b0;
    old = '0;
    q_old = '0;
    q_line = '0;

    if (req.sample_valid) begin
      decimate_count_next = decimate_count + 1'b1;
      take = (decimate_count_next == '0) || (skip_left_next != '0);
      if (vbat_src && discard_left_next == '0 && take) begin
        if (skip_left_next != '0) begin
          for (int k = 0; k < LINE_DEPTH; k++) begin
            line_next[k] = req.sample;
          end
          skip_left_next = skip_left_next - 1'b1;
        end else begin
          for (int k = 0; k < LINE_DEPTH - 1; k++) begin
            line_next[k] = line_next[k + 1];
          end
          line_next[LINE_DEPTH-1] = req.sample;
        end
        old = line_next[0];
        q_old = blm_pkg::quantise(thr, old);
        if (!usb_mode_next && old < thr[blm_pkg::SAMPLE_BITS-1:0] && !req.usb_present_raw) begin
          action = blm_pkg::ACT_POWER_OFF;
          done = 1'b1;
        end else if (q_old.level < level_now_next) begin
          level_pending_next = q_old.level;
          action = blm_pkg::ACT_NEW_LEVEL;
          done = 1'b1;
        end
      end
      if (!done && discard_left_next != '0) begin
        discard_left_next = discard_left_next - 1'b1;
      end
    end

    q_line = blm_pkg::quantise(thr, line_next[0]);
    if (!done) begin
      if (boot_notify_next) begin
        if (q_line.found) begin
          level_pending_next = q_line.level;
        end
        action = blm_pkg::ACT_NEW_LEVEL;
      end else if (aux_update_next != '0) begin
        if (aux_update_next >= level_now_next) begin
          if (aux_update_next < blm_pkg::LEVEL_UNKNOWN) begin
            for (int k = 0; k < LINE_DEPTH; k++) begin
              line_next[k] = blm_pkg::thr_at(thr, aux_update_next);
            end
          end
          level_pending_next = aux_update_next;
          action = blm_pkg::ACT_NEW_LEVEL;
        end else begin
          aux_update_next = '0;
        end
      end
    end

    if (level_now_next >= blm_pkg::LEVEL_UNKNOWN) begin
      if (line_next[0] < blm_pkg::thr_at(thr, 4'd2)) bat = blm_pkg::BAT_EMPTY;
      else if (line_next[0] < blm_pkg::thr_at(thr, 4'd4)) bat = blm_pkg::BAT_QUARTER;
      else if (line_next[0] < blm_pkg::thr_at(thr, 4'd6)) bat = blm_pkg::BAT_HALF;
      else if (line_next[0] < blm_pkg::thr_at(thr, 4'd8)) bat = blm_pkg::BAT_THREE_QT;
      else bat = blm_pkg::BAT_FULL;
    end else if (error_flag_next) begin
      bat = blm_pkg::BAT_ERROR;
    end else if (level_now_next < 4'd2) begin
      bat = blm_pkg::BAT_EMPTY;
    end else if (level_now_next < 4'd4) begin
      bat = blm_pkg::BAT_QUARTER;
    end else if (level_now_next < 4'd6) begin
      bat = blm_pkg::BAT_HALF;
    end else if (level_now_next < 4'd8) begin
      bat = blm_pkg::BAT_THREE_QT;
    end else begin
      bat = blm_pkg::BAT_FULL;
    end

    rsp.action = action;
    rsp.pending_level = level_pending_next;
    rsp.current_level = level_now_next;
    rsp.battery_state = bat;
    rsp.on_usb = usb_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usb_mode <= 1'b0;
      last_powered <= 1'b0;
      for (int k = 0; k < LINE_DEPTH; k++) begin
        line[k] <= '0;
      end
      decimate_count <= '0;
      discard_left <= '0;
      skip_left <= '0;
      level_now <= blm_pkg::LEVEL_UNKNOWN;
      level_pending <= '0;
      aux_update <= '0;
      boot_notify <= 1'b1;
      error_flag <= 1'b0;
    end else if (step) begin
      usb_mode <= usb_mode_next;
      last_powered <= req.stepup_powered;
      for (int k = 0; k < LINE_DEPTH; k++) begin
        line[k] <= line_next[k];
      end
      decimate_count <= decimate_count_next;
      discard_left <= discard_left_next;
      skip_left <= skip_left_next;
      level_now <= level_now_next;
      level_pending <= level_pending_next;
      aux_update <= aux_update_next;
      boot_notify <= boot_notify_next;
      error_flag <= error_flag_next;
    end
  end

endmodule

// File: src/battery_level_monitor.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   blm_pkg::req_t, one routine call
// rsp       out        rsp_valid/rsp_stall   blm_pkg::rsp_t, one result per item
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data (threshold words)
//
// Each item is registered, processed combinationally against the state, and its
// result is registered; one item can enter per cycle while req_stall is low.
// The synchronous reset clears the handshake state and all monitor state.
// A stalled result holds the output register; the input register still takes
// one more item, and req_stall rises only when both registers are full.
module battery_level_monitor #(
  parameter int LINE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  blm_pkg::req_t                        req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output blm_pkg::rsp_t                        rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [blm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [blm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic [4*blm_pkg::SAMPLE_BITS-1:0] thr_low;
  logic [4*blm_pkg::SAMPLE_BITS-1:0] thr_mid;
  logic [3*blm_pkg::SAMPLE_BITS-1:0] thr_high;
  blm_pkg::thr_set_t thr;

  logic in_full;
  blm_pkg::req_t in_item;
  logic advance;
  logic accept;
  blm_pkg::rsp_t result;

  assign cfg_ready = 1'b1;
  assign thr = {thr_high, thr_mid, thr_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_low <= '0;
      thr_mid <= '0;
      thr_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (blm_pkg::cfg_index_t'(cfg_index))
        blm_pkg::CFG_THR_LOW:  thr_low <= cfg_data;
        blm_pkg::CFG_THR_MID:  thr_mid <= cfg_data;
        blm_pkg::CFG_THR_HIGH: thr_high <= cfg_data[3*blm_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign advance = in_full && (!rsp_valid || !rsp_stall);
  assign req_stall = in_full && rsp_valid && rsp_stall;
  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= req;
    end
  end

  blm_core #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .req (in_item),
    .thr (thr),
    .rsp (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

// File: tb/sv/tb_battery_level_monitor.sv
module tb_battery_level_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  import blm_pkg::*;

  localparam int LINE_DEPTH = 8;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int REQ_BITS = $bits(req_t);

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_stall;
  req_t                      req;
  logic                      rsp_valid;
  logic                      rsp_stall;
  rsp_t                      rsp;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  battery_level_monitor #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Local copy of the monitor state and its thresholds.
  sample_t                 thr_m [NUM_LEVELS];
  sample_t                 next_thr [NUM_LEVELS];
  sample_t                 line_m [LINE_DEPTH];
  logic                    usb_mode_m;
  logic                    powered_m;
  logic                    boot_m;
  logic                    error_m;
  logic [DECIM_BITS-1:0]   decim_m;
  logic [DISCARD_BITS-1:0] discard_m;
  logic [SKIP_BITS-1:0]    skip_m;
  level_t                  level_now_m;
  level_t                  pending_m;
  level_t                  aux_m;

  rsp_t levels_due [$];
  int   mismatches;
  int   results_seen;
  bit   gaps_on;
  bit   stalls_on;
  logic usb_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic void reset_monitor_model();
    for (int i = 0; i < NUM_LEVELS; i++) thr_m[i] = '0;
    for (int i = 0; i < LINE_DEPTH; i++) line_m[i] = '0;
    usb_mode_m = 1'b0;
    powered_m = 1'b0;
    boot_m = 1'b1;
    error_m = 1'b0;
    decim_m = '0;
    discard_m = '0;
    skip_m = '0;
    level_now_m = LEVEL_UNKNOWN;
    pending_m = '0;
    aux_m = '0;
  endfunction

  function automatic void fill_line(input sample_t v);
    for (int i = 0; i < LINE_DEPTH; i++) line_m[i] = v;
  endfunction

  function automatic logic highest_level(input sample_t v, output level_t lvl);
    lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (v > thr_m[i]) begin
        lvl = level_t'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic action_t run_routine(input req_t r);
    logic    from_bat;
    logic    take;
    level_t  lvl;
    sample_t oldest;
    from_bat = r.stepup_on_battery && r.stepup_powered;
    if (!usb_mode_m && r.usb_present) begin
      fill_line(line_m[0]);
      usb_mode_m = 1'b1;
    end else if (usb_mode_m && !r.usb_present) begin
      usb_mode_m = 1'b0;
      discard_m = DISCARD_DETACH;
    end else if (!powered_m && r.stepup_powered) begin
      discard_m = (skip_m != 0) ? DISCARD_QUICK : DISCARD_WAKE;
    end
    powered_m = r.stepup_powered;

    if (r.sample_valid) begin
      decim_m = decim_m + 1'b1;
      take = (decim_m == 0) || (skip_m != 0);
      if (from_bat && discard_m == 0 && take) begin
        if (skip_m != 0) begin
          fill_line(r.sample);
          skip_m = skip_m - 1'b1;
        end else begin
          for (int i = 0; i < LINE_DEPTH - 1; i++) line_m[i] = line_m[i + 1];
          line_m[LINE_DEPTH - 1] = r.sample;
        end
        oldest = line_m[0];
        if (!usb_mode_m && oldest < thr_m[0] && !r.usb_present_raw) return ACT_POWER_OFF;
        void'(highest_level(oldest, lvl));
        if (lvl < level_now_m) begin
          pending_m = lvl;
          return ACT_NEW_LEVEL;
        end
      end
      if (discard_m != 0) discard_m = discard_m - 1'b1;
    end

    if (boot_m) begin
      if (highest_level(line_m[0], lvl)) pending_m = lvl;
      return ACT_NEW_LEVEL;
    end

    if (aux_m != 0) begin
      if (aux_m >= level_now_m) begin
        if (aux_m < LEVEL_UNKNOWN) fill_line(thr_m[aux_m]);
        pending_m = aux_m;
        return ACT_NEW_LEVEL;
      end
      aux_m = '0;
    end
    return ACT_NONE;
  endfunction

  function automatic bat_state_t battery_state_now();
    if (level_now_m >= LEVEL_UNKNOWN) begin
      if (line_m[0] < thr_m[2]) return BAT_EMPTY;
      if (line_m[0] < thr_m[4]) return BAT_QUARTER;
      if (line_m[0] < thr_m[6]) return BAT_HALF;
      if (line_m[0] < thr_m[8]) return BAT_THREE_QT;
      return BAT_FULL;
    end
    if (error_m) return BAT_ERROR;
    if (level_now_m < 2) return BAT_EMPTY;
    if (level_now_m < 4) return BAT_QUARTER;
    if (level_now_m < 6) return BAT_HALF;
    if (level_now_m < 8) return BAT_THREE_QT;
    return BAT_FULL;
  endfunction

  function automatic rsp_t advance_monitor(input req_t r);
    rsp_t o;
    if (r.ack) begin
      level_now_m = pending_m;
      boot_m = 1'b0;
      aux_m = '0;
    end
    if (r.error_signal) error_m = 1'b1;
    if (r.skip_queue_request) skip_m = SKIP_ARM;
    if (r.aux_level != 0) aux_m = r.aux_level;
    o.action = run_routine(r);
    o.pending_level = pending_m;
    o.current_level = level_now_m;
    o.battery_state = battery_state_now();
    o.on_usb = usb_mode_m;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 200) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (levels_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
      end else begin
        want = levels_due.pop_front();
        if (rsp.action !== want.action)
          report_mismatch($sformatf("result %0d action: got %0d, expected %0d",
                                    results_seen, rsp.action, want.action));
        if (rsp.pending_level !== want.pending_level)
          report_mismatch($sformatf("result %0d pending_level: got %0d, expected %0d",
                                    results_seen, rsp.pending_level, want.pending_level));
        if (rsp.current_level !== want.current_level)
          report_mismatch($sformatf("result %0d current_level: got %0d, expected %0d",
                                    results_seen, rsp.current_level, want.current_level));
        if (rsp.battery_state !== want.battery_state)
          report_mismatch($sformatf("result %0d battery_state: got %0d, expected %0d",
                                    results_seen, rsp.battery_state, want.battery_state));
        if (rsp.on_usb !== want.on_usb)
          report_mismatch($sformatf("result %0d on_usb: got %0d, expected %0d",
                                    results_seen, rsp.on_usb, want.on_usb));
      end
    end
  end

  function automatic int pick_stall();
    int p;
    p = $urandom_range(99);
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  initial begin : drive_stall
    int left;
    left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
        rsp_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(99) < 20) begin
        left = pick_stall() - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (!gaps_on || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_call(input req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    levels_due.push_back(advance_monitor(r));
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
  endtask

  task automatic write_thresholds(input cfg_index_t idx, input int first, input int count);
    logic [CFG_DATA_BITS-1:0] word;
    word = '0;
    for (int k = 0; k < count; k++) word[k * SAMPLE_BITS +: SAMPLE_BITS] = next_thr[first + k];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    for (int k = 0; k < count; k++) thr_m[first + k] = next_thr[first + k];
  endtask

  task automatic load_thresholds();
    write_thresholds(CFG_THR_LOW, 0, 4);
    write_thresholds(CFG_THR_MID, 4, 4);
    write_thresholds(CFG_THR_HIGH, 8, 3);
    cfg_valid <= 1'b0;
  endtask

  function automatic void ascending_thresholds();
    for (int i = 0; i < NUM_LEVELS; i++) next_thr[i] = sample_t'(1200 + 200 * i);
  endfunction

  function automatic req_t battery_call(input logic valid, input sample_t s);
    req_t r;
    r = '0;
    r.stepup_on_battery = 1'b1;
    r.stepup_powered = 1'b1;
    r.sample_valid = valid;
    r.sample = s;
    return r;
  endfunction

  function automatic sample_t pick_sample();
    int v;
    if ($urandom_range(1) == 0) return sample_t'($urandom_range(SAMPLE_MAX));
    v = int'(thr_m[$urandom_range(NUM_LEVELS - 1)]) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return sample_t'(v);
  endfunction

  function automatic req_t random_call(input bit err_ok);
    logic [REQ_BITS-1:0] raw;
    req_t r;
    if ($urandom_range(99) < 12) begin
      raw = REQ_BITS'($urandom);
      r = raw;
      if (!err_ok) r.error_signal = 1'b0;
      return r;
    end
    if ($urandom_range(99) < 2) usb_hold = ~usb_hold;
    r.usb_present = usb_hold;
    r.usb_present_raw = ($urandom_range(9) == 0);
    r.stepup_on_battery = ($urandom_range(19) != 0);
    r.stepup_powered = ($urandom_range(29) != 0);
    r.sample_valid = ($urandom_range(4) != 0);
    r.sample = pick_sample();
    r.ack = ($urandom_range(7) == 0);
    r.aux_level = ($urandom_range(24) == 0) ? level_t'($urandom_range(1, 15)) : level_t'(0);
    r.skip_queue_request = ($urandom_range(29) == 0);
    r.error_signal = err_ok && ($urandom_range(99) == 0);
    return r;
  endfunction

  task automatic run_traffic(input int count, input bit err_ok);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        gaps_on = ($urandom_range(3) != 0);
        stalls_on = ($urandom_range(3) != 0);
      end
      if ($urandom_range(149) == 0) wait_idle();
      send_call(random_call(err_ok));
    end
  endtask

  task automatic test_directed_calls();
    req_t r;
    wait_idle();
    ascending_thresholds();
    load_thresholds();
    send_call(battery_call(1'b0, '0));
    r = battery_call(1'b1, sample_t'(SAMPLE_MAX));
    repeat (5) send_call(r);
    r.skip_queue_request = 1'b1;
    send_call(r);
    r = battery_call(1'b0, '0);
    r.ack = 1'b1;
    send_call(r);
    send_call(battery_call(1'b1, sample_t'(2500)));
    send_call(r);
    send_call(battery_call(1'b1, '0));
    r = battery_call(1'b1, '0);
    r.skip_queue_request = 1'b1;
    r.usb_present_raw = 1'b1;
    send_call(r);
    r = battery_call(1'b0, '0);
    r.ack = 1'b1;
    r.aux_level = level_t'(15);
    send_call(r);
    r = battery_call(1'b0, '0);
    r.aux_level = level_t'(7);
    send_call(r);
    r = battery_call(1'b0, '0);
    r.ack = 1'b1;
    send_call(r);
    r.ack = 1'b0;
    r.aux_level = level_t'(3);
    send_call(r);
    r = battery_call(1'b1, thr_m[5]);
    r.skip_queue_request = 1'b1;
    send_call(r);
    r = battery_call(1'b0, '0);
    r.usb_present = 1'b1;
    send_call(r);
    r = battery_call(1'b1, '0);
    r.usb_present = 1'b1;
    r.skip_queue_request = 1'b1;
    send_call(r);
    send_call(battery_call(1'b1, sample_t'(SAMPLE_MAX)));
    r = battery_call(1'b0, '0);
    r.stepup_powered = 1'b0;
    send_call(r);
    r = battery_call(1'b1, sample_t'(3000));
    r.skip_queue_request = 1'b1;
    send_call(r);
    r.stepup_on_battery = 1'b0;
    send_call(r);
  endtask

  task automatic test_open_thresholds();
    wait_idle();
    for (int i = 0; i < NUM_LEVELS; i++) next_thr[i] = '0;
    load_thresholds();
    run_traffic(300, 1'b0);
  endtask

  task automatic test_closed_thresholds();
    wait_idle();
    for (int i = 0; i < NUM_LEVELS; i++) next_thr[i] = sample_t'(SAMPLE_MAX);
    load_thresholds();
    run_traffic(300, 1'b0);
  endtask

  task automatic test_mixed_traffic();
    wait_idle();
    ascending_thresholds();
    load_thresholds();
    run_traffic(600, 1'b0);
  endtask

  task automatic test_shuffled_thresholds();
    wait_idle();
    for (int i = 0; i < NUM_LEVELS; i++) next_thr[i] = sample_t'($urandom_range(SAMPLE_MAX));
    load_thresholds();
    run_traffic(400, 1'b0);
  endtask

  task automatic test_sticky_error();
    req_t r;
    wait_idle();
    ascending_thresholds();
    load_thresholds();
    r = battery_call(1'b1, sample_t'(2000));
    r.error_signal = 1'b1;
    r.ack = 1'b1;
    send_call(r);
    run_traffic(250, 1'b1);
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_THR_LOW;
    cfg_data <= '0;
    mismatches = 0;
    results_seen = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    usb_hold = 1'b0;
    reset_monitor_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_calls();
    test_open_thresholds();
    test_closed_thresholds();
    test_mixed_traffic();
    test_shuffled_thresholds();
    test_sticky_error();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
